@@ rtl/core/bvtm_pkg.sv @@
// Shared widths, register indexes, classifier constants and codes for the battery monitor.
`default_nettype none

package bvtm_pkg;

   // Field widths
   localparam int SAMPLE_W   = 14;
   localparam int MAG_W      = 13;
   localparam int VREF_W     = 11;
   localparam int MV_W       = 14;
   localparam int PCT_W      = 7;
   localparam int CSR_DATA_W = 14;
   localparam int CSR_ADDR_W = 2;

   // Default burst length
   localparam int BURST_LENGTH_DEF = 8;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_VREF    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEEP    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SUSPEND = 2'd2;

   // Register reset values
   localparam logic [VREF_W-1:0] VREF_RESET    = 11'd1200;
   localparam logic [MV_W-1:0]   DEEP_RESET    = 14'd2100;
   localparam logic [MV_W-1:0]   SUSPEND_RESET = 14'd1800;

   // Level steps (mV lower bounds, exclusive) and percentages
   localparam logic [MV_W-1:0] LVL_100_MV = 14'd3000;
   localparam logic [MV_W-1:0] LVL_90_MV  = 14'd2800;
   localparam logic [MV_W-1:0] LVL_70_MV  = 14'd2600;
   localparam logic [MV_W-1:0] LVL_40_MV  = 14'd2400;
   localparam logic [MV_W-1:0] LVL_20_MV  = 14'd2300;

   localparam logic [PCT_W-1:0] PCT_100 = 7'd100;
   localparam logic [PCT_W-1:0] PCT_90  = 7'd90;
   localparam logic [PCT_W-1:0] PCT_70  = 7'd70;
   localparam logic [PCT_W-1:0] PCT_40  = 7'd40;
   localparam logic [PCT_W-1:0] PCT_20  = 7'd20;
   localparam logic [PCT_W-1:0] PCT_0   = 7'd0;

   // Minimum level change that gets reported
   localparam logic [PCT_W-1:0] HYST_STEP = 7'd2;

   // Margin above the deep threshold for a good battery
   localparam logic [MV_W:0] GOOD_MARGIN_MV = 15'd200;

   // Scaling shift after multiplying by the reference
   localparam int SCALE_SHIFT = 10;

   typedef enum logic [1:0] {
      STATUS_GOOD = 2'd0,
      STATUS_POOR = 2'd1,
      STATUS_LOW  = 2'd2
   } batt_status_type;

   typedef enum logic [1:0] {
      PWR_NORMAL  = 2'd0,
      PWR_DEEP    = 2'd1,
      PWR_SUSPEND = 2'd2
   } pwr_action_type;

endpackage

`default_nettype wire

@@ rtl/core/battery_voltage_trimmed_mean_monitor_unit.sv @@
// Battery monitor: insertion-sorted burst, trimmed mean, scaling and level classifier.
// After a request the block is busy with insertion (one compare-and-shift per cycle,
//   the sample sinking until it reaches its sorted position).
// On the last sample of a burst it then sums the kept entries (one adder pass per kept
//   entry) and runs mean multiply, scale multiply and classify; the result strobe follows.
// One request per busy period: start is taken only while idle; no stall from the receiver.
// Reset (synchronous, active high) clears the burst position and reported level and
//   loads the register defaults.
`default_nettype none

module battery_voltage_trimmed_mean_monitor_unit #(
   parameter int BURST_LENGTH = bvtm_pkg::BURST_LENGTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [bvtm_pkg::SAMPLE_W-1:0]  req_raw_sample,
   input  wire logic                           req_link_connected,
   output logic                                rsp_valid,
   output logic [bvtm_pkg::MV_W-1:0]           rsp_voltage_mv,
   output logic [bvtm_pkg::PCT_W-1:0]          rsp_percent,
   output logic                                rsp_notify,
   output logic [1:0]                          rsp_battery_status,
   output logic [1:0]                          rsp_power_action,
   input  wire logic                           csr_we,
   input  wire logic [bvtm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [bvtm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import bvtm_pkg::*;

   localparam int TRIM      = BURST_LENGTH / 4;
   localparam int KEEP      = BURST_LENGTH - 2 * TRIM;
   localparam int IDX_W     = $clog2(BURST_LENGTH);
   localparam int SUM_W     = $clog2(KEEP * ((1 << MAG_W) - 1) + 1);
   localparam int RECIP_SH  = 20;
   localparam int RECIP     = ((1 << RECIP_SH) + KEEP - 1) / KEEP;
   localparam int MUL_B_W   = 21;
   localparam int PROD_W    = SUM_W + MUL_B_W;

   localparam logic [IDX_W-1:0] LAST_POS  = IDX_W'(BURST_LENGTH - 1);
   localparam logic [IDX_W-1:0] FIRST_KEEP = IDX_W'(TRIM);
   localparam logic [IDX_W-1:0] LAST_KEEP = IDX_W'(TRIM + KEEP - 1);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_INSERT   = 6'b000010,
      ST_SUM      = 6'b000100,
      ST_DIV      = 6'b001000,
      ST_SCALE    = 6'b010000,
      ST_CLASSIFY = 6'b100000
   } state_type;

   // Control and payload registers
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   sample_index_ff, sample_index_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   acc_idx_ff, acc_idx_in;
   logic [MAG_W-1:0]   key_ff, key_in;
   logic               link_ff, link_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [MAG_W-1:0]   avg_ff, avg_in;
   logic [MV_W-1:0]    mv_ff, mv_in;
   logic [PCT_W-1:0]   reported_ff, reported_in;

   logic [VREF_W-1:0]  vref_ff;
   logic [MV_W-1:0]    deep_ff;
   logic [MV_W-1:0]    suspend_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]    rsp_mv_ff, rsp_mv_in;
   logic [PCT_W-1:0]   rsp_pct_ff, rsp_pct_in;
   logic               rsp_notify_ff, rsp_notify_in;
   batt_status_type    rsp_status_ff, rsp_status_in;
   pwr_action_type     rsp_action_ff, rsp_action_in;

   // Sorted sample store
   logic [MAG_W-1:0]   sort_ff [BURST_LENGTH];
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [MAG_W-1:0]   wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [MAG_W-1:0]   rd_data;

   // Shared multiplier
   logic [SUM_W-1:0]   mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;

   // Classifier terms
   logic [MAG_W-1:0]   req_mag;
   logic [PCT_W-1:0]   pct;
   logic [PCT_W-1:0]   diff;
   logic [MV_W:0]      good_mv;
   logic               is_low;

   assign req_mag = req_raw_sample[SAMPLE_W-1] ? '0 : req_raw_sample[MAG_W-1:0];

   // Read port: neighbor below during insertion, kept entry while summing
   always_comb begin
      if (state_ff == ST_SUM) begin
         rd_addr = acc_idx_ff;
      end else begin
         rd_addr = pos_ff - IDX_W'(1);
      end
   end

   assign rd_data = sort_ff[rd_addr];

   // Multiplier operands: reciprocal of KEEP for the mean, then the reference
   always_comb begin
      if (state_ff == ST_DIV) begin
         mul_a = acc_ff;
         mul_b = MUL_B_W'(RECIP);
      end else begin
         mul_a = SUM_W'(avg_ff);
         mul_b = MUL_B_W'(vref_ff);
      end
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Stepped level from the voltage
   always_comb begin
      if (mv_ff > LVL_100_MV) begin
         pct = PCT_100;
      end else if (mv_ff > LVL_90_MV) begin
         pct = PCT_90;
      end else if (mv_ff > LVL_70_MV) begin
         pct = PCT_70;
      end else if (mv_ff > LVL_40_MV) begin
         pct = PCT_40;
      end else if (mv_ff > LVL_20_MV) begin
         pct = PCT_20;
      end else begin
         pct = PCT_0;
      end
   end

   assign diff    = (reported_ff > pct) ? (reported_ff - pct) : (pct - reported_ff);
   assign good_mv = {1'b0, deep_ff} + GOOD_MARGIN_MV;
   assign is_low  = mv_ff < deep_ff;

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      sample_index_in = sample_index_ff;
      pos_in          = pos_ff;
      key_in          = key_ff;
      link_in         = link_ff;
      acc_in          = acc_ff;
      acc_idx_in      = acc_idx_ff;
      avg_in          = avg_ff;
      mv_in           = mv_ff;
      reported_in     = reported_ff;
      rsp_valid_in    = 1'b0;
      rsp_mv_in       = rsp_mv_ff;
      rsp_pct_in      = rsp_pct_ff;
      rsp_notify_in   = rsp_notify_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_action_in   = rsp_action_ff;
      wr_en           = 1'b0;
      wr_addr         = pos_ff;
      wr_data         = key_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in   = req_mag;
               pos_in   = sample_index_ff;
               link_in  = req_link_connected;
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            wr_en = 1'b1;
            if ((pos_ff != '0) && (rd_data > key_ff)) begin
               // shift larger neighbor up, keep sinking
               wr_data = rd_data;
               pos_in  = pos_ff - IDX_W'(1);
            end else begin
               wr_data = key_ff;
               if (sample_index_ff == LAST_POS) begin
                  sample_index_in = '0;
                  acc_in          = '0;
                  acc_idx_in      = FIRST_KEEP;
                  state_in        = ST_SUM;
               end else begin
                  sample_index_in = sample_index_ff + IDX_W'(1);
                  state_in        = ST_IDLE;
               end
            end
         end
         ST_SUM: begin
            acc_in = acc_ff + SUM_W'(rd_data);
            if (acc_idx_ff == LAST_KEEP) begin
               state_in = ST_DIV;
            end else begin
               acc_idx_in = acc_idx_ff + IDX_W'(1);
            end
         end
         ST_DIV: begin
            avg_in   = prod[RECIP_SH +: MAG_W];
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            mv_in    = prod[SCALE_SHIFT +: MV_W];
            state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            rsp_valid_in  = 1'b1;
            rsp_mv_in     = mv_ff;
            rsp_pct_in    = pct;
            rsp_notify_in = 1'b0;
            if (diff >= HYST_STEP) begin
               reported_in   = pct;
               rsp_notify_in = link_ff;
            end
            if ({1'b0, mv_ff} > good_mv) begin
               rsp_status_in = STATUS_GOOD;
            end else if (is_low) begin
               rsp_status_in = STATUS_LOW;
            end else begin
               rsp_status_in = STATUS_POOR;
            end
            if (!is_low) begin
               rsp_action_in = PWR_NORMAL;
            end else if (mv_ff <= suspend_ff) begin
               rsp_action_in = PWR_SUSPEND;
            end else begin
               rsp_action_in = PWR_DEEP;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sample_index_ff <= '0;
         reported_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sample_index_ff <= sample_index_in;
         reported_ff     <= reported_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vref_ff    <= VREF_RESET;
         deep_ff    <= DEEP_RESET;
         suspend_ff <= SUSPEND_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_VREF:    vref_ff    <= csr_wdata[VREF_W-1:0];
            CSR_DEEP:    deep_ff    <= csr_wdata[MV_W-1:0];
            CSR_SUSPEND: suspend_ff <= csr_wdata[MV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      link_ff       <= link_in;
      acc_ff        <= acc_in;
      acc_idx_ff    <= acc_idx_in;
      avg_ff        <= avg_in;
      mv_ff         <= mv_in;
      rsp_mv_ff     <= rsp_mv_in;
      rsp_pct_ff    <= rsp_pct_in;
      rsp_notify_ff <= rsp_notify_in;
      rsp_status_ff <= rsp_status_in;
      rsp_action_ff <= rsp_action_in;
   end

   // Sample store write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sort_ff[wr_addr] <= wr_data;
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_voltage_mv     = rsp_mv_ff;
   assign rsp_percent        = rsp_pct_ff;
   assign rsp_notify         = rsp_notify_ff;
   assign rsp_battery_status = rsp_status_ff;
   assign rsp_power_action   = rsp_action_ff;

`ifndef ASSERT_OFF
   // A result only follows the classify step
   a_rsp_after_classify: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_CLASSIFY))
      else $error("result strobe without classify step");

   // Burst position stays inside the burst
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      sample_index_ff <= LAST_POS)
      else $error("burst position out of range");

   // A sleep action (deep or suspend) is only requested for a low battery
   a_suspend_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_power_action != PWR_NORMAL)) |-> (rsp_battery_status == STATUS_LOW))
      else $error("sleep action without low status");

   // A notification always carries the level that is now recorded as the last report
   a_notify_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_notify) |-> (reported_ff == rsp_percent))
      else $error("notification without level update");
`endif

endmodule

`default_nettype wire
